// ===== sv/four_channel_dma_controller_defines.svh =====
// assertion macros for the dma controller
`ifndef FOUR_CHANNEL_DMA_CONTROLLER_DEFINES_SVH
`define FOUR_CHANNEL_DMA_CONTROLLER_DEFINES_SVH
`define DMA_ASSERT_IMPL(label, clk, rstn, a, c) \
    label: assert property (@(posedge clk) disable iff (!rstn) (a) |-> (c)) \
        else $error("dma check failed");
`define DMA_ASSERT_NEXT(label, clk, rstn, a, c) \
    label: assert property (@(posedge clk) disable iff (!rstn) (a) |=> (c)) \
        else $error("dma check failed");
`endif

// ===== sv/fcdma_pkg.sv =====
// shared types and constants for the dma controller
package fcdma_pkg;
    localparam int NumChannels = 4;
    localparam int MaxBudget = 32;
    localparam int ChW = 2;
    localparam int BudW = 6;

    localparam logic [2:0] CmdWrite = 3'd0;
    localparam logic [2:0] CmdRead = 3'd1;
    localparam logic [2:0] CmdHblank = 3'd2;
    localparam logic [2:0] CmdVblank = 3'd3;
    localparam logic [2:0] CmdRun = 3'd4;
    localparam logic [2:0] CmdSuspend = 3'd5;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_EXEC,
        ST_XFER,
        ST_DONE
    } state_t;

    typedef struct packed {
        logic exec;
        logic start_run;
        logic beat;
        logic xfer;
        logic finish;
    } cmd_t;

    typedef struct packed {
        logic run_ok;
        logic more;
    } stat_t;

    function automatic logic [3:0] step_of(logic [1:0] ctrl, logic word);
        logic [3:0] s;
        s = word ? 4'd4 : 4'd2;
        case (ctrl)
            2'd2: step_of = 4'd0;
            2'd1: step_of = 4'd0 - s;
            default: step_of = s;
        endcase
    endfunction
endpackage

// ===== sv/four_channel_dma_controller.sv =====
// top level of the four channel dma controller
// usage:
//   the s_ channel carries one command word: register write or read, hblank,
//   vblank, run or suspend. the m_ channel returns result words, the final one
//   of each command marked by m_last.
//   a non-run command is accepted, executed, then answered with one result word.
//   a run on an active channel emits one transfer word per cycle while m_ready
//   is high, up to min(budget capped at 32, units left), then the channel state
//   is updated on the word that carries m_last. the rate is set by the single
//   shared address update unit and the sequencer, which handles one command at
//   a time.
//   reset clears all channel registers, flags and the sequencer.
//   when the receiver holds m_ready low, the current result word holds and
//   no new command is accepted until the final word is taken.
//   read data for open bus bytes is zero here and flagged in m_open_bus_mask.
//   zero count means 0x4000 units, 0x10000 on channel 3.
//   a run with a zero budget gives a single empty word.
`include "four_channel_dma_controller_defines.svh"
module four_channel_dma_controller (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [2:0]  s_command,
    input  logic [1:0]  s_access_size,
    input  logic [5:0]  s_reg_offset,
    input  logic [31:0] s_write_data,
    input  logic [1:0]  s_channel,
    input  logic [5:0]  s_unit_budget,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [31:0] m_read_data,
    output logic [3:0]  m_open_bus_mask,
    output logic        m_xfer_valid,
    output logic [31:0] m_xfer_src,
    output logic [31:0] m_xfer_dst,
    output logic        m_xfer_word,
    output logic        m_irq_raise,
    output logic [3:0]  m_active_mask,
    output logic        m_last
);
    fcdma_pkg::cmd_t  cmd;
    fcdma_pkg::stat_t stat;
    logic is_run;

    fcdma_ctrl u_ctrl (
        .aclk(aclk), .aresetn(aresetn), .s_valid(s_valid), .s_ready(s_ready),
        .m_valid(m_valid), .m_ready(m_ready), .is_run(is_run), .stat(stat), .cmd(cmd)
    );

    fcdma_datapath u_dp (
        .aclk(aclk), .aresetn(aresetn), .take(s_valid && s_ready),
        .s_command(s_command), .s_access_size(s_access_size),
        .s_reg_offset(s_reg_offset), .s_write_data(s_write_data),
        .s_channel(s_channel), .s_unit_budget(s_unit_budget),
        .cmd(cmd), .stat(stat), .is_run(is_run),
        .m_read_data(m_read_data), .m_open_bus_mask(m_open_bus_mask),
        .m_xfer_valid(m_xfer_valid), .m_xfer_src(m_xfer_src),
        .m_xfer_dst(m_xfer_dst), .m_xfer_word(m_xfer_word),
        .m_irq_raise(m_irq_raise), .m_active_mask(m_active_mask), .m_last(m_last)
    );

    `DMA_ASSERT_IMPL(a_no_overlap, aclk, aresetn, s_ready, !m_valid)
    `DMA_ASSERT_IMPL(a_irq_last, aclk, aresetn, m_valid && m_irq_raise, m_last)
    `DMA_ASSERT_NEXT(a_last_idle, aclk, aresetn, m_valid && m_ready && m_last, s_ready)
    `DMA_ASSERT_IMPL(a_xfer_run, aclk, aresetn, m_valid && m_xfer_valid,
                     m_open_bus_mask == 4'd0)
endmodule

// ===== sv/fcdma_ctrl.sv =====
// sequencer for the dma controller
module fcdma_ctrl (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    output logic              m_valid,
    input  logic              m_ready,
    input  logic              is_run,
    input  fcdma_pkg::stat_t  stat,
    output fcdma_pkg::cmd_t   cmd
);
    fcdma_pkg::state_t state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= fcdma_pkg::ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            fcdma_pkg::ST_IDLE: begin
                if (s_valid) state_next = fcdma_pkg::ST_EXEC;
            end
            fcdma_pkg::ST_EXEC: begin
                if (is_run && stat.run_ok && stat.more) state_next = fcdma_pkg::ST_XFER;
                else state_next = fcdma_pkg::ST_DONE;
            end
            fcdma_pkg::ST_XFER: begin
                if (m_ready && !stat.more) state_next = fcdma_pkg::ST_IDLE;
            end
            fcdma_pkg::ST_DONE: begin
                if (m_ready) state_next = fcdma_pkg::ST_IDLE;
            end
            default: state_next = fcdma_pkg::ST_IDLE;
        endcase
    end

    always_comb begin
        s_ready = 1'b0;
        m_valid = 1'b0;
        cmd = '0;
        case (state_reg)
            fcdma_pkg::ST_IDLE: s_ready = 1'b1;
            fcdma_pkg::ST_EXEC: begin
                cmd.exec = 1'b1;
                cmd.start_run = is_run && stat.run_ok;
            end
            fcdma_pkg::ST_XFER: begin
                m_valid = 1'b1;
                cmd.beat = 1'b1;
                cmd.xfer = m_ready;
            end
            fcdma_pkg::ST_DONE: begin
                m_valid = 1'b1;
                cmd.finish = m_ready;
            end
            default: ;
        endcase
    end
endmodule

// ===== sv/fcdma_datapath.sv =====
// channel registers, access decode and transfer address generation
module fcdma_datapath (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             take,
    input  logic [2:0]                       s_command,
    input  logic [1:0]                       s_access_size,
    input  logic [5:0]                       s_reg_offset,
    input  logic [31:0]                      s_write_data,
    input  logic [1:0]                       s_channel,
    input  logic [5:0]                       s_unit_budget,
    input  fcdma_pkg::cmd_t                  cmd,
    output fcdma_pkg::stat_t                 stat,
    output logic                             is_run,
    output logic [31:0]                      m_read_data,
    output logic [3:0]                       m_open_bus_mask,
    output logic                             m_xfer_valid,
    output logic [31:0]                      m_xfer_src,
    output logic [31:0]                      m_xfer_dst,
    output logic                             m_xfer_word,
    output logic                             m_irq_raise,
    output logic [3:0]                       m_active_mask,
    output logic                             m_last
);
    localparam int N = fcdma_pkg::NumChannels;

    logic [27:0] src_start_reg [N];
    logic [27:0] dst_start_reg [N];
    logic [15:0] count_start_reg [N];
    logic [15:0] control_reg [N];
    logic [31:0] src_now_reg [N];
    logic [31:0] dst_now_reg [N];
    logic [16:0] units_reg [N];
    logic [3:0]  src_step_reg [N];
    logic [3:0]  dst_step_reg [N];
    logic [N-1:0] susp_reg, rep_reg, act_reg;

    logic [2:0]  cmd_reg;
    logic [1:0]  size_reg;
    logic [5:0]  off_reg;
    logic [31:0] data_reg;
    logic [1:0]  ch_reg;
    logic [5:0]  bud_reg;
    logic [5:0]  n_reg;
    logic [31:0] rd_reg;
    logic [3:0]  obm_reg;
    logic        irq_reg;

    logic [27:0] src_start_next [N];
    logic [27:0] dst_start_next [N];
    logic [15:0] count_start_next [N];
    logic [15:0] control_next [N];
    logic [31:0] src_now_next [N];
    logic [31:0] dst_now_next [N];
    logic [16:0] units_next [N];
    logic [3:0]  src_step_next [N];
    logic [3:0]  dst_step_next [N];
    logic [N-1:0] susp_next, rep_next, act_next;
    logic [31:0] rd_next;
    logic [3:0]  obm_next;

    logic        ch_ok;
    logic [15:0] cw;
    logic        word;
    logic [16:0] units_run;
    logic [5:0]  bud_sat;
    logic [N-1:0] mask_w;
    logic        run_ok_w;
    logic        more_w;

    function automatic logic [1:0] ch_of(logic [5:0] o);
        if (o < 6'd12) ch_of = 2'd0;
        else if (o < 6'd24) ch_of = 2'd1;
        else if (o < 6'd36) ch_of = 2'd2;
        else ch_of = 2'd3;
    endfunction

    function automatic logic [3:0] sub_of(logic [5:0] o);
        logic [5:0] r;
        if (o < 6'd12) r = o;
        else if (o < 6'd24) r = o - 6'd12;
        else if (o < 6'd36) r = o - 6'd24;
        else r = o - 6'd36;
        sub_of = r[3:0];
    endfunction

    function automatic logic [16:0] reload_of(logic [15:0] cs, logic [1:0] c);
        if (cs != 16'd0) reload_of = {1'b0, cs};
        else if (c == 2'd3) reload_of = 17'h10000;
        else reload_of = 17'h04000;
    endfunction

    assign is_run = (cmd_reg == fcdma_pkg::CmdRun);
    assign ch_ok = (32'(ch_reg) < 32'(N));
    assign cw = control_reg[ch_reg];
    assign word = cw[10];
    assign units_run = units_reg[ch_reg];
    assign bud_sat = (32'(bud_reg) > 32'(fcdma_pkg::MaxBudget)) ?
                     6'(fcdma_pkg::MaxBudget) : bud_reg;
    assign run_ok_w = ch_ok && act_reg[ch_reg];
    assign stat = '{run_ok: run_ok_w, more: more_w};

    always_comb begin
        for (int i = 0; i < N; i++) begin
            if ((32'(ch_reg) == i) && cmd.start_run && !susp_reg[i] && rep_reg[i])
                mask_w[i] = 1'b0;
            else
                mask_w[i] = 1'b0;
        end
    end

    // units available for this run, counting a pending reload
    logic [16:0] units_eff;
    always_comb begin
        units_eff = units_run;
        if (cmd.exec && !susp_reg[ch_reg] && rep_reg[ch_reg])
            units_eff = reload_of(count_start_reg[ch_reg], ch_reg);
        if (cmd.exec) more_w = (units_eff != 17'd0) && (bud_sat != 6'd0);
        else more_w = (units_run > 17'd1) && (n_reg + 6'd1 < bud_sat);
    end

    // register writes and events
    always_comb begin
        logic [1:0] c;
        logic [3:0] s;
        logic [5:0] o;
        logic [15:0] h;
        logic [15:0] prev;
        logic [7:0] b;
        for (int i = 0; i < N; i++) begin
            src_start_next[i] = src_start_reg[i];
            dst_start_next[i] = dst_start_reg[i];
            count_start_next[i] = count_start_reg[i];
            control_next[i] = control_reg[i];
            src_now_next[i] = src_now_reg[i];
            dst_now_next[i] = dst_now_reg[i];
            units_next[i] = units_reg[i];
            src_step_next[i] = src_step_reg[i];
            dst_step_next[i] = dst_step_reg[i];
        end
        susp_next = susp_reg;
        rep_next = rep_reg;
        act_next = act_reg;
        rd_next = 32'd0;
        obm_next = 4'd0;
        c = 2'd0;
        s = 4'd0;
        o = 6'd0;
        h = 16'd0;
        prev = 16'd0;
        b = 8'd0;
        if (cmd.exec) begin
            case (cmd_reg)
                fcdma_pkg::CmdWrite: begin
                    if (size_reg == 2'd0) begin
                        o = off_reg;
                        b = data_reg[7:0];
                        if (32'(o) < 12 * N) begin
                            c = ch_of(o);
                            s = sub_of(o);
                            if (s < 4'd4) begin
                                if (s == 4'd3) src_start_next[c][27:24] = b[3:0];
                                else src_start_next[c][8*s[1:0] +: 8] = b;
                            end else if (s < 4'd8) begin
                                if (s == 4'd7) dst_start_next[c][27:24] = b[3:0];
                                else dst_start_next[c][8*s[1:0] +: 8] = b;
                            end else if (s < 4'd10) begin
                                count_start_next[c][8*s[0] +: 8] = b;
                                if (c != 2'd3) count_start_next[c][15:14] = 2'd0;
                            end else if (s == 4'd10) begin
                                control_next[c][7:0] = b;
                            end else begin
                                control_next[c][15:8] = b;
                            end
                        end
                    end else begin
                        for (int k = 0; k < 2; k++) begin
                            o = off_reg + 6'(2 * k);
                            h = k == 0 ? data_reg[15:0] : data_reg[31:16];
                            if ((k == 0 || size_reg != 2'd1) && (32'(off_reg) +
                                32'(2 * k) < 12 * N)) begin
                                c = ch_of(o);
                                s = sub_of(o);
                                if (size_reg != 2'd1 && k == 0 && (s == 4'd0 || s == 4'd4))
                                begin
                                    if (s == 4'd0) src_start_next[c] = data_reg[27:0];
                                    else dst_start_next[c] = data_reg[27:0];
                                end else if (size_reg != 2'd1 && k == 1 &&
                                             (sub_of(off_reg) == 4'd0 ||
                                              sub_of(off_reg) == 4'd4)) begin
                                end else begin
                                    case (s)
                                        4'd0: src_start_next[c][15:0] = h;
                                        4'd2: src_start_next[c][27:16] = h[11:0];
                                        4'd4: dst_start_next[c][15:0] = h;
                                        4'd6: dst_start_next[c][27:16] = h[11:0];
                                        4'd8: count_start_next[c] =
                                            (c == 2'd3) ? h : {2'd0, h[13:0]};
                                        4'd10: control_next[c] = h;
                                        default: ;
                                    endcase
                                end
                            end
                        end
                    end
                    for (int i = 0; i < N; i++) begin
                        prev = control_reg[i];
                        if (control_next[i][15] != prev[15] && !(size_reg == 2'd0 &&
                            sub_of(off_reg) == 4'd10)) begin
                            if (control_next[i][15]) begin
                                rep_next[i] = 1'b0;
                                susp_next[i] = 1'b0;
                                units_next[i] = reload_of(count_start_next[i], 2'(i));
                                src_now_next[i] = {4'd0, src_start_next[i]};
                                dst_now_next[i] = {4'd0, dst_start_next[i]};
                                if (control_next[i][13:12] == 2'd0) act_next[i] = 1'b1;
                            end else begin
                                act_next[i] = 1'b0;
                            end
                        end
                    end
                end
                fcdma_pkg::CmdRead: begin
                    if (size_reg == 2'd0) begin
                        o = off_reg;
                        c = ch_of(o);
                        s = sub_of(o);
                        if (32'(o) >= 12 * N || s < 4'd8) obm_next = 4'b0001;
                        else if (s == 4'd10) rd_next = {24'd0, control_reg[c][7:0]};
                        else if (s == 4'd11) rd_next = {24'd0, control_reg[c][15:8]};
                    end else begin
                        for (int k = 0; k < 2; k++) begin
                            o = off_reg + 6'(2 * k);
                            c = ch_of(o);
                            s = sub_of(o);
                            if (k == 0 || size_reg != 2'd1) begin
                                if (32'(off_reg) + 32'(2 * k) >= 12 * N ||
                                    !(s == 4'd8 || s == 4'd10))
                                    obm_next[2*k +: 2] = 2'b11;
                                else if (s == 4'd10)
                                    rd_next[16*k +: 16] = control_reg[c];
                            end
                        end
                    end
                end
                fcdma_pkg::CmdHblank, fcdma_pkg::CmdVblank: begin
                    for (int i = 0; i < N; i++) begin
                        if (control_reg[i][15] && control_reg[i][13:12] ==
                            ((cmd_reg == fcdma_pkg::CmdHblank) ? 2'd2 : 2'd1))
                            act_next[i] = 1'b1;
                    end
                end
                fcdma_pkg::CmdSuspend: begin
                    if (ch_ok) susp_next[ch_reg] = 1'b1;
                end
                fcdma_pkg::CmdRun: begin
                    if (run_ok_w) begin
                        if (susp_reg[ch_reg]) begin
                            susp_next[ch_reg] = 1'b0;
                        end else begin
                            if (rep_reg[ch_reg]) begin
                                units_next[ch_reg] =
                                    reload_of(count_start_reg[ch_reg], ch_reg);
                                if (cw[6:5] == 2'd3)
                                    dst_now_next[ch_reg] = {4'd0, dst_start_reg[ch_reg]};
                            end
                            dst_step_next[ch_reg] = fcdma_pkg::step_of(cw[6:5], word);
                            src_step_next[ch_reg] = fcdma_pkg::step_of(cw[8:7], word);
                        end
                    end
                end
                default: ;
            endcase
        end
        if (cmd.xfer) begin
            units_next[ch_reg] = units_run - 17'd1;
            src_now_next[ch_reg] = src_now_reg[ch_reg] +
                {{28{src_step_reg[ch_reg][3]}}, src_step_reg[ch_reg]};
            dst_now_next[ch_reg] = dst_now_reg[ch_reg] +
                {{28{dst_step_reg[ch_reg][3]}}, dst_step_reg[ch_reg]};
            if (units_run == 17'd1) begin
                act_next[ch_reg] = 1'b0;
                if (!cw[9]) control_next[ch_reg][15] = 1'b0;
                else rep_next[ch_reg] = 1'b1;
            end
        end
        if (cmd.finish && is_run && run_ok_w && units_run == 17'd0) begin
            act_next[ch_reg] = 1'b0;
            if (!cw[9]) control_next[ch_reg][15] = 1'b0;
            else rep_next[ch_reg] = 1'b1;
        end
    end

    // run with zero units left finishes in the done word
    logic finish_now;
    assign finish_now = is_run && run_ok_w && units_run == 17'd0 && !irq_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < N; i++) begin
                src_start_reg[i] <= '0;
                dst_start_reg[i] <= '0;
                count_start_reg[i] <= '0;
                control_reg[i] <= '0;
                src_now_reg[i] <= '0;
                dst_now_reg[i] <= '0;
                units_reg[i] <= '0;
                src_step_reg[i] <= '0;
                dst_step_reg[i] <= '0;
            end
            susp_reg <= '0;
            rep_reg <= '0;
            act_reg <= '0;
            cmd_reg <= '0;
            n_reg <= '0;
            irq_reg <= 1'b0;
        end else begin
            for (int i = 0; i < N; i++) begin
                src_start_reg[i] <= src_start_next[i];
                dst_start_reg[i] <= dst_start_next[i];
                count_start_reg[i] <= count_start_next[i];
                control_reg[i] <= control_next[i];
                src_now_reg[i] <= src_now_next[i];
                dst_now_reg[i] <= dst_now_next[i];
                units_reg[i] <= units_next[i];
                src_step_reg[i] <= src_step_next[i];
                dst_step_reg[i] <= dst_step_next[i];
            end
            susp_reg <= susp_next;
            rep_reg <= rep_next | mask_w;
            act_reg <= act_next;
            if (take) begin
                cmd_reg <= s_command;
                n_reg <= '0;
                irq_reg <= 1'b0;
            end
            if (cmd.xfer) n_reg <= n_reg + 6'd1;
            if (cmd.exec) irq_reg <= 1'b0;
            if (cmd.xfer && units_run == 17'd1) irq_reg <= 1'b1;
            if (cmd.finish) irq_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (take) begin
            size_reg <= s_access_size;
            off_reg <= s_reg_offset;
            data_reg <= s_write_data;
            ch_reg <= s_channel;
            bud_reg <= s_unit_budget;
        end
        if (cmd.exec) begin
            rd_reg <= rd_next;
            obm_reg <= obm_next;
        end
    end

    // result word: a transfer while units are flowing, the closing word otherwise
    logic in_xfer;
    assign in_xfer = cmd.beat;
    always_comb begin
        m_read_data = is_run ? 32'd0 : rd_reg;
        m_open_bus_mask = is_run ? 4'd0 : obm_reg;
        m_xfer_valid = in_xfer;
        m_xfer_src = in_xfer ? src_now_reg[ch_reg] : 32'd0;
        m_xfer_dst = in_xfer ? dst_now_reg[ch_reg] : 32'd0;
        m_xfer_word = in_xfer ? word : 1'b0;
        m_last = !(in_xfer && more_w);
        m_irq_raise = m_last && cw[14] && is_run &&
                      ((in_xfer && units_run == 17'd1) || irq_reg || finish_now);
        m_active_mask = 4'(act_reg);
        if (m_last && is_run && run_ok_w &&
            ((in_xfer && units_run == 17'd1) || finish_now))
            m_active_mask[ch_reg] = 1'b0;
    end
endmodule

// ===== tb/tb_four_channel_dma_controller.sv =====
// self-checking testbench for the four channel dma controller
`timescale 1ns / 1ps

module tb_four_channel_dma_controller;

    typedef struct {
        logic [31:0] rdata;
        logic [3:0]  obm;
        logic        xv;
        logic [31:0] xsrc;
        logic [31:0] xdst;
        logic        xword;
        logic        irq;
        logic [3:0]  amask;
        logic        last;
    } dma_word_t;

    class dma_scoreboard;
        logic [27:0] src_base[4];
        logic [27:0] dst_base[4];
        logic [15:0] cnt_base[4];
        logic [15:0] ctrl[4];
        logic [31:0] src_cur[4];
        logic [31:0] dst_cur[4];
        logic [16:0] remaining[4];
        logic [3:0]  sstep[4];
        logic [3:0]  dstep[4];
        bit          susp[4];
        bit          rep[4];
        bit          act[4];
        dma_word_t   pending[$];
        int          errors;
        int          checked;

        function new();
            for (int i = 0; i < 4; i++) begin
                src_base[i] = 0; dst_base[i] = 0; cnt_base[i] = 0; ctrl[i] = 0;
                src_cur[i] = 0; dst_cur[i] = 0; remaining[i] = 0;
                sstep[i] = 0; dstep[i] = 0; susp[i] = 0; rep[i] = 0; act[i] = 0;
            end
            errors = 0;
            checked = 0;
        endfunction

        function logic [3:0] amask_now();
            for (int i = 0; i < 4; i++) amask_now[i] = act[i];
        endfunction

        function logic [15:0] cmask(int ch);
            return ch == 3 ? 16'hFFFF : 16'h3FFF;
        endfunction

        function void reload(int ch);
            if (cnt_base[ch] == 0) remaining[ch] = ch == 3 ? 17'h10000 : 17'h4000;
            else remaining[ch] = {1'b0, cnt_base[ch]};
        endfunction

        function void set_ctrl(int ch, logic [15:0] v);
            logic [15:0] prev;
            prev = ctrl[ch];
            ctrl[ch] = v;
            if (prev[15] == v[15]) return;
            if (v[15]) begin
                rep[ch] = 0;
                susp[ch] = 0;
                reload(ch);
                src_cur[ch] = {4'h0, src_base[ch]};
                dst_cur[ch] = {4'h0, dst_base[ch]};
                if (v[13:12] == 0) act[ch] = 1;
            end else begin
                act[ch] = 0;
            end
        endfunction

        function void wr_byte(int off, logic [7:0] b);
            int ch, sub;
            if (off >= 48) return;
            ch = off / 12;
            sub = off % 12;
            if (sub < 4) begin
                if (sub == 3) src_base[ch][27:24] = b[3:0];
                else src_base[ch][8*sub +: 8] = b;
            end else if (sub < 8) begin
                if (sub == 7) dst_base[ch][27:24] = b[3:0];
                else dst_base[ch][8*(sub-4) +: 8] = b;
            end else if (sub < 10) begin
                cnt_base[ch][8*(sub-8) +: 8] = b;
                cnt_base[ch] = cnt_base[ch] & cmask(ch);
            end else if (sub == 10) begin
                ctrl[ch][7:0] = b;
            end else begin
                set_ctrl(ch, {b, ctrl[ch][7:0]});
            end
        endfunction

        function void wr_half(int off, logic [15:0] h);
            int ch, sub;
            if (off >= 48) return;
            ch = off / 12;
            sub = off % 12;
            case (sub)
                0: src_base[ch][15:0] = h;
                2: src_base[ch][27:16] = h[11:0];
                4: dst_base[ch][15:0] = h;
                6: dst_base[ch][27:16] = h[11:0];
                8: cnt_base[ch] = h & cmask(ch);
                10: set_ctrl(ch, h);
                default: ;
            endcase
        endfunction

        function bit rd_byte(int off, output logic [7:0] v);
            int sub;
            v = 0;
            if (off >= 48 || off % 12 < 8) return 1;
            sub = off % 12;
            if (sub == 10) v = ctrl[off/12][7:0];
            else if (sub == 11) v = ctrl[off/12][15:8];
            return 0;
        endfunction

        function bit rd_half(int off, output logic [15:0] v);
            v = 0;
            if (off >= 48) return 1;
            if (off % 12 == 8) return 0;
            if (off % 12 == 10) begin
                v = ctrl[off/12];
                return 0;
            end
            return 1;
        endfunction

        function logic [3:0] step_for(logic [1:0] c, bit w);
            logic [3:0] s;
            s = w ? 4'd4 : 4'd2;
            if (c == 2) return 0;
            if (c == 1) return 4'd0 - s;
            return s;
        endfunction

        function void push_word(logic [31:0] rd, logic [3:0] obm, logic xv,
                                logic [31:0] xs, logic [31:0] xd, logic xw,
                                logic irq, logic [3:0] am, logic lst);
            dma_word_t r;
            r.rdata = rd; r.obm = obm; r.xv = xv; r.xsrc = xs; r.xdst = xd;
            r.xword = xw; r.irq = irq; r.amask = am; r.last = lst;
            pending.push_back(r);
        endfunction

        function void run_channel(int ch, int budget);
            logic [15:0] c;
            bit w;
            int n;
            dma_word_t r;
            c = ctrl[ch];
            w = c[10];
            if (budget > fcdma_pkg::MaxBudget) budget = fcdma_pkg::MaxBudget;
            if (susp[ch]) begin
                susp[ch] = 0;
            end else begin
                if (rep[ch]) begin
                    reload(ch);
                    if (c[6:5] == 3) dst_cur[ch] = {4'h0, dst_base[ch]};
                end
                dstep[ch] = step_for(c[6:5], w);
                sstep[ch] = step_for(c[8:7], w);
            end
            n = 0;
            while (remaining[ch] > 0 && n < budget) begin
                push_word(0, 0, 1, src_cur[ch], dst_cur[ch], w, 0, amask_now(), 0);
                remaining[ch]--;
                dst_cur[ch] += {{28{dstep[ch][3]}}, dstep[ch]};
                src_cur[ch] += {{28{sstep[ch][3]}}, sstep[ch]};
                n++;
            end
            if (n == 0) push_word(0, 0, 0, 0, 0, 0, 0, 0, 0);
            r = pending.pop_back();
            if (remaining[ch] == 0) begin
                act[ch] = 0;
                if (c[14]) r.irq = 1;
                if (c[9]) rep[ch] = 1;
                else ctrl[ch][15] = 0;
            end
            r.amask = amask_now();
            r.last = 1;
            pending.push_back(r);
        endfunction

        function void note_command(logic [2:0] cmd, logic [1:0] sz, logic [5:0] off,
                                   logic [31:0] data, logic [1:0] ch, logic [5:0] bud);
            logic [31:0] rd;
            logic [3:0] obm;
            logic [7:0] b;
            logic [15:0] h;
            int o;
            rd = 0;
            obm = 0;
            o = off;
            if (cmd == fcdma_pkg::CmdRun) begin
                if (act[ch]) begin
                    run_channel(ch, bud);
                    return;
                end
            end else if (cmd == fcdma_pkg::CmdWrite) begin
                if (sz == 0) wr_byte(o, data[7:0]);
                else if (sz == 1) wr_half(o, data[15:0]);
                else if (o < 48 && (o % 12 == 0)) src_base[o/12] = data[27:0];
                else if (o < 48 && (o % 12 == 4)) dst_base[o/12] = data[27:0];
                else begin
                    wr_half(o, data[15:0]);
                    wr_half(o + 2, data[31:16]);
                end
            end else if (cmd == fcdma_pkg::CmdRead) begin
                if (sz == 0) begin
                    if (rd_byte(o, b)) obm = 1; else rd = {24'h0, b};
                end else begin
                    if (rd_half(o, h)) obm = 3; else rd = {16'h0, h};
                    if (sz != 1) begin
                        if (rd_half(o + 2, h)) obm |= 4'hC; else rd |= {h, 16'h0};
                    end
                end
            end else if (cmd == fcdma_pkg::CmdHblank || cmd == fcdma_pkg::CmdVblank) begin
                for (int i = 0; i < 4; i++)
                    if (ctrl[i][15] && ctrl[i][13:12] ==
                        (cmd == fcdma_pkg::CmdHblank ? 2'd2 : 2'd1))
                        act[i] = 1;
            end else if (cmd == fcdma_pkg::CmdSuspend) begin
                susp[ch] = 1;
            end
            push_word(rd, obm, 0, 0, 0, 0, 0, amask_now(), 1);
        endfunction

        task check_word(dma_word_t got);
            dma_word_t e;
            checked++;
            if (pending.size() == 0) begin
                report("unexpected word", 0, 0);
                return;
            end
            e = pending.pop_front();
            if (got.rdata !== e.rdata) report("read_data", got.rdata, e.rdata);
            if (got.obm !== e.obm) report("open_bus_mask", 32'(got.obm), 32'(e.obm));
            if (got.xv !== e.xv) report("xfer_valid", 32'(got.xv), 32'(e.xv));
            if (got.xsrc !== e.xsrc) report("xfer_src", got.xsrc, e.xsrc);
            if (got.xdst !== e.xdst) report("xfer_dst", got.xdst, e.xdst);
            if (got.xword !== e.xword) report("xfer_word", 32'(got.xword), 32'(e.xword));
            if (got.irq !== e.irq) report("irq_raise", 32'(got.irq), 32'(e.irq));
            if (got.amask !== e.amask) report("active_mask", 32'(got.amask), 32'(e.amask));
            if (got.last !== e.last) report("last", 32'(got.last), 32'(e.last));
        endtask

        task report(string what, logic [31:0] got, logic [31:0] want);
            errors++;
            $display("[%0t] %s: got %h want %h (word %0d)", $realtime, what, got,
                     want, checked);
        endtask
    endclass

    logic        aclk = 0;
    logic        aresetn = 0;
    logic        s_valid = 0;
    logic        s_ready;
    logic [2:0]  s_command = 0;
    logic [1:0]  s_access_size = 0;
    logic [5:0]  s_reg_offset = 0;
    logic [31:0] s_write_data = 0;
    logic [1:0]  s_channel = 0;
    logic [5:0]  s_unit_budget = 0;
    logic        m_valid;
    logic        m_ready = 0;
    logic [31:0] m_read_data;
    logic [3:0]  m_open_bus_mask;
    logic        m_xfer_valid;
    logic [31:0] m_xfer_src;
    logic [31:0] m_xfer_dst;
    logic        m_xfer_word;
    logic        m_irq_raise;
    logic [3:0]  m_active_mask;
    logic        m_last;

    dma_scoreboard sb = new();
    int n_cmds = 0;
    int n_xfers = 0;
    bit stall_free = 0;

    four_channel_dma_controller dut (.*);

    always begin
        #4 aclk = 1;
        #4 aclk = 0;
    end

    initial begin
        #4_000_000;
        $display("four_channel_dma_controller: mismatch");
        $finish;
    end

    // receiver stall pattern
    always @(negedge aclk) begin
        if (stall_free) m_ready <= 1;
        else m_ready <= ($urandom_range(0, 3) != 0);
    end

    always @(posedge aclk) begin
        dma_word_t w;
        if (aresetn && m_valid && m_ready) begin
            w.rdata = m_read_data; w.obm = m_open_bus_mask; w.xv = m_xfer_valid;
            w.xsrc = m_xfer_src; w.xdst = m_xfer_dst; w.xword = m_xfer_word;
            w.irq = m_irq_raise; w.amask = m_active_mask; w.last = m_last;
            if (m_xfer_valid) n_xfers++;
            sb.check_word(w);
        end
    end

    task automatic send_cmd(logic [2:0] cmd, logic [1:0] sz, logic [5:0] off,
                            logic [31:0] data, logic [1:0] ch, logic [5:0] bud);
        s_valid <= 1;
        s_command <= cmd;
        s_access_size <= sz;
        s_reg_offset <= off;
        s_write_data <= data;
        s_channel <= ch;
        s_unit_budget <= bud;
        do @(posedge aclk); while (!s_ready);
        sb.note_command(cmd, sz, off, data, ch, bud);
        n_cmds++;
        @(negedge aclk);
    endtask

    task automatic idle_gap();
        s_valid <= 0;
        repeat ($urandom_range(1, 6)) @(negedge aclk);
    endtask

    task automatic setup_channel(int ch, bit small_cnt);
        logic [15:0] c;
        c = 16'($urandom);
        c[15] = 0;
        send_cmd(fcdma_pkg::CmdWrite, 2, 6'(12 * ch), $urandom, 0, 0);
        send_cmd(fcdma_pkg::CmdWrite, 2, 6'(12 * ch + 4), $urandom, 0, 0);
        send_cmd(fcdma_pkg::CmdWrite, 1, 6'(12 * ch + 8),
                 small_cnt ? $urandom_range(1, 40) : $urandom, 0, 0);
        send_cmd(fcdma_pkg::CmdWrite, 1, 6'(12 * ch + 10), {16'h0, c}, 0, 0);
        c[15] = 1;
        send_cmd(fcdma_pkg::CmdWrite, 1, 6'(12 * ch + 10), {16'h0, c}, 0, 0);
    endtask

    task automatic random_noise();
        send_cmd(3'($urandom_range(0, 7)), 2'($urandom_range(0, 3)), 6'($urandom),
                 $urandom, 2'($urandom), 6'($urandom));
    endtask

    initial begin
        int burst;
        repeat (6) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1;
        @(negedge aclk);

        // directed: extremes, every command, zero counts and odd accesses
        send_cmd(fcdma_pkg::CmdWrite, 2, 0, 32'hFFFF_FFFF, 0, 0);
        send_cmd(fcdma_pkg::CmdWrite, 2, 4, 32'hFFFF_FFFF, 0, 0);
        send_cmd(fcdma_pkg::CmdWrite, 1, 8, 32'h0, 0, 0);
        send_cmd(fcdma_pkg::CmdWrite, 1, 10, 32'h0000_C7E0, 0, 0);
        send_cmd(fcdma_pkg::CmdRun, 0, 0, 0, 0, 0);
        send_cmd(fcdma_pkg::CmdRun, 0, 0, 0, 0, 6'h3F);
        send_cmd(fcdma_pkg::CmdSuspend, 0, 0, 0, 0, 0);
        send_cmd(fcdma_pkg::CmdRun, 0, 0, 0, 0, 1);
        send_cmd(fcdma_pkg::CmdRead, 3, 8, 0, 0, 0);
        send_cmd(fcdma_pkg::CmdRead, 0, 11, 0, 0, 0);
        send_cmd(fcdma_pkg::CmdRead, 2, 2, 0, 0, 0);
        send_cmd(fcdma_pkg::CmdRead, 1, 63, 0, 0, 0);
        send_cmd(fcdma_pkg::CmdWrite, 0, 47, 32'hFF, 0, 0);
        send_cmd(fcdma_pkg::CmdWrite, 0, 46, 32'h21, 0, 0);
        send_cmd(fcdma_pkg::CmdWrite, 2, 44, 32'hFFFF_0000, 0, 0);
        send_cmd(fcdma_pkg::CmdWrite, 0, 47, 32'hB2, 0, 0);
        send_cmd(fcdma_pkg::CmdVblank, 0, 0, 0, 0, 0);
        send_cmd(fcdma_pkg::CmdRun, 0, 0, 0, 3, 32);
        send_cmd(fcdma_pkg::CmdWrite, 2, 33, 32'hA5A5_5A5A, 0, 0);
        send_cmd(fcdma_pkg::CmdHblank, 0, 0, 0, 0, 0);
        send_cmd(fcdma_pkg::CmdRun, 0, 0, 0, 2, 5);
        send_cmd(fcdma_pkg::CmdWrite, 0, 63, 32'h0, 0, 0);
        send_cmd(6, 0, 0, 0, 0, 0);
        send_cmd(7, 0, 0, 0, 0, 0);
        send_cmd(fcdma_pkg::CmdRead, 2, 34, 0, 0, 0);

        // random: mostly channel setups and runs, some noise
        while (n_cmds < 260) begin
            burst = $urandom_range(1, 8);
            stall_free = ($urandom_range(0, 4) == 0);
            for (int k = 0; k < burst; k++) begin
                case ($urandom_range(0, 9))
                    0, 1: setup_channel($urandom_range(0, 3), $urandom_range(0, 7) != 0);
                    2, 3, 4, 5: send_cmd(fcdma_pkg::CmdRun, 0, 0, 0, 2'($urandom),
                                         6'($urandom_range(0, 40)));
                    6: send_cmd($urandom_range(0, 1) ? fcdma_pkg::CmdHblank :
                                fcdma_pkg::CmdVblank, 0, 0, 0, 0, 0);
                    7: send_cmd(fcdma_pkg::CmdSuspend, 0, 0, 0, 2'($urandom), 0);
                    default: random_noise();
                endcase
            end
            if ($urandom_range(0, 2) != 0) idle_gap();
        end
        s_valid <= 0;
        stall_free = 1;

        while (sb.pending.size() != 0) @(posedge aclk);
        repeat (20) @(posedge aclk);
        $display("ran %0d commands, checked %0d result words, %0d of them transfers",
                 n_cmds, sb.checked, n_xfers);
        if (sb.errors == 0 && sb.pending.size() == 0)
            $display("four_channel_dma_controller: match");
        else
            $display("four_channel_dma_controller: mismatch");
        $finish;
    end
endmodule
